// ----- hdl/spq_pkg.sv -----
package spq_pkg;

    localparam int NUM_LEVELS  = 16;
    localparam int CAPACITY    = 64;
    localparam int HANDLE_BITS = 16;

    localparam int LVL_W     = $clog2(NUM_LEVELS);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LCNT_W    = $clog2(NUM_LEVELS + 1);
    localparam int REC_DEPTH = 1 << IDX_W;

    localparam logic [15:0] HANDLE_MASK =
        (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << HANDLE_BITS) - 32'd1);

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_POP     = 3'd1;
    localparam logic [2:0] CMD_FINISH  = 3'd2;
    localparam logic [2:0] CMD_BLOCK   = 3'd3;
    localparam logic [2:0] CMD_UNBLOCK = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_MISUSE = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  level;
        logic [15:0] handle;
        logic        blocks_others;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_handle;
        logic [3:0]  out_level;
        logic        urgent_present;
        logic        is_empty;
        logic [4:0]  levels_in_use;
        logic        blocked;
    } rsp_item_t;

endpackage

// ----- hdl/spq_if.sv -----
interface spq_req_if;
    import spq_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/stable_priority_queue.sv -----
// channel | dir | payload                                            | handshake
// req     | in  | cmd, level, handle, blocks_others                  | valid/ready
// rsp     | out | status, out_handle, out_level, urgent_present,     | valid/ready
//         |     | is_empty, levels_in_use, blocked                   |
//
// one item per cycle while req.ready is high; a pop that leaves items on its level
// holds req.ready low while the level's head cache is reloaded from the entry
// memory (one registered read)
// reset is asynchronous; entry storage needs no clearing pass
// a waiting result in the output register stalls req only when rsp.ready is low
module stable_priority_queue (
    input logic       clk,
    input logic       rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    // per-level control and head cache
    logic [NUM_LEVELS-1:0] nonempty_reg;
    logic [NUM_LEVELS-1:0] one_reg;
    logic [IDX_W-1:0]      head_idx_reg  [NUM_LEVELS];
    logic [IDX_W-1:0]      tail_idx_reg  [NUM_LEVELS];
    logic [IDX_W-1:0]      head_next_reg [NUM_LEVELS];
    logic [15:0]           head_hnd_reg  [NUM_LEVELS];
    logic                  head_blk_reg  [NUM_LEVELS];

    // entry memories
    logic [16:0]      ent_data_mem [CAPACITY];
    logic [IDX_W-1:0] ent_link_mem [CAPACITY];
    logic [16:0]      ent_data_rd_reg;
    logic [IDX_W-1:0] ent_link_rd_reg;

    // recycled entry fifo
    logic [IDX_W-1:0] rec_mem [REC_DEPTH];
    logic [IDX_W-1:0] rec_wr_ptr_reg, rec_rd_ptr_reg, rec_rd_ptr_next;
    logic [IDX_W-1:0] rec_rdata_reg;

    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic [CNT_W-1:0]  item_cnt_reg, item_cnt_next;
    logic [LCNT_W-1:0] lvl_cnt_reg, lvl_cnt_next;
    logic              in_proc_reg, in_proc_next;
    logic              blocked_reg, blocked_next;
    logic              refill_reg, refill_next;
    logic [LVL_W-1:0]  refill_lvl_reg;

    logic      rsp_valid_reg;
    rsp_item_t rsp_data_reg, rsp_next;

    logic             accept;
    logic             top_any;
    logic [LVL_W-1:0] top_lvl;
    logic [LVL_W-1:0] ins_lvl;
    logic [15:0]      hnd;
    logic             ins_ok, pop_ok, pop_rec, need_refill;
    logic [IDX_W-1:0] alloc_idx, pop_idx;

    assign req.ready = !refill_reg && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // most urgent non-empty level
    always_comb
    begin
        top_any = |nonempty_reg;
        top_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                top_lvl = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        if (32'(req.data.level) < NUM_LEVELS)
        begin
            ins_lvl = LVL_W'(req.data.level);
        end
        else
        begin
            ins_lvl = LVL_W'(NUM_LEVELS - 1);
        end
    end

    assign hnd         = req.data.handle & HANDLE_MASK;
    assign alloc_idx   = (fresh_reg < CNT_W'(CAPACITY)) ? fresh_reg[IDX_W-1:0] : rec_rdata_reg;
    assign pop_idx     = head_idx_reg[top_lvl];
    assign ins_ok      = accept && req.data.cmd == CMD_INSERT
                         && item_cnt_reg < CNT_W'(CAPACITY);
    assign pop_ok      = accept && req.data.cmd == CMD_POP && top_any
                         && !in_proc_reg && !blocked_reg;
    assign pop_rec     = ins_ok && fresh_reg == CNT_W'(CAPACITY);
    assign need_refill = pop_ok && !one_reg[top_lvl];
    assign rec_rd_ptr_next = pop_rec ? rec_rd_ptr_reg + 1'b1 : rec_rd_ptr_reg;

    always_comb
    begin
        fresh_next    = fresh_reg;
        item_cnt_next = item_cnt_reg;
        lvl_cnt_next  = lvl_cnt_reg;
        in_proc_next  = in_proc_reg;
        blocked_next  = blocked_reg;
        refill_next   = 1'b0;
        rsp_next      = '0;
        if (accept)
        begin
            case (req.data.cmd)
                CMD_INSERT:
                begin
                    if (!ins_ok)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        item_cnt_next = item_cnt_reg + 1'b1;
                        if (!pop_rec)
                        begin
                            fresh_next = fresh_reg + 1'b1;
                        end
                        if (!nonempty_reg[ins_lvl])
                        begin
                            lvl_cnt_next = lvl_cnt_reg + 1'b1;
                        end
                    end
                end
                CMD_POP:
                begin
                    if (!top_any)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else if (in_proc_reg || blocked_reg)
                    begin
                        rsp_next.status = ST_MISUSE;
                    end
                    else
                    begin
                        rsp_next.out_handle = head_hnd_reg[top_lvl];
                        rsp_next.out_level  = 4'(top_lvl);
                        item_cnt_next       = item_cnt_reg - 1'b1;
                        in_proc_next        = 1'b1;
                        blocked_next        = head_blk_reg[top_lvl];
                        refill_next         = need_refill;
                        if (one_reg[top_lvl])
                        begin
                            lvl_cnt_next = lvl_cnt_reg - 1'b1;
                        end
                    end
                end
                CMD_FINISH:
                begin
                    if (!in_proc_reg)
                    begin
                        rsp_next.status = ST_MISUSE;
                    end
                    else
                    begin
                        in_proc_next = 1'b0;
                        blocked_next = 1'b0;
                    end
                end
                CMD_BLOCK:
                begin
                    if (blocked_reg)
                    begin
                        rsp_next.status = ST_MISUSE;
                    end
                    else
                    begin
                        blocked_next = 1'b1;
                    end
                end
                CMD_UNBLOCK:
                begin
                    if (!blocked_reg)
                    begin
                        rsp_next.status = ST_MISUSE;
                    end
                    else
                    begin
                        blocked_next = 1'b0;
                    end
                end
                CMD_QUERY:
                begin
                    rsp_next.urgent_present = top_any && (32'(top_lvl) < 32'(req.data.level));
                end
                default:
                begin
                end
            endcase
        end
        rsp_next.is_empty      = (item_cnt_next == '0);
        rsp_next.levels_in_use = 5'(lvl_cnt_next);
        rsp_next.blocked       = blocked_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg   <= '0;
            one_reg        <= '0;
            fresh_reg      <= '0;
            item_cnt_reg   <= '0;
            lvl_cnt_reg    <= '0;
            in_proc_reg    <= 1'b0;
            blocked_reg    <= 1'b0;
            refill_reg     <= 1'b0;
            rec_wr_ptr_reg <= '0;
            rec_rd_ptr_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            fresh_reg      <= fresh_next;
            item_cnt_reg   <= item_cnt_next;
            lvl_cnt_reg    <= lvl_cnt_next;
            in_proc_reg    <= in_proc_next;
            blocked_reg    <= blocked_next;
            refill_reg     <= refill_next;
            rec_rd_ptr_reg <= rec_rd_ptr_next;
            if (pop_ok)
            begin
                rec_wr_ptr_reg <= rec_wr_ptr_reg + 1'b1;
            end
            if (ins_ok)
            begin
                nonempty_reg[ins_lvl] <= 1'b1;
                one_reg[ins_lvl]      <= !nonempty_reg[ins_lvl];
            end
            if (pop_ok)
            begin
                if (one_reg[top_lvl])
                begin
                    nonempty_reg[top_lvl] <= 1'b0;
                end
                else
                begin
                    one_reg[top_lvl] <= (head_next_reg[top_lvl] == tail_idx_reg[top_lvl]);
                end
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // head and tail pointers, head cache, result data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_next;
        end
        if (ins_ok)
        begin
            tail_idx_reg[ins_lvl] <= alloc_idx;
            if (!nonempty_reg[ins_lvl])
            begin
                head_idx_reg[ins_lvl] <= alloc_idx;
                head_hnd_reg[ins_lvl] <= hnd;
                head_blk_reg[ins_lvl] <= req.data.blocks_others;
            end
            else if (one_reg[ins_lvl])
            begin
                head_next_reg[ins_lvl] <= alloc_idx;
            end
        end
        if (need_refill)
        begin
            head_idx_reg[top_lvl] <= head_next_reg[top_lvl];
            refill_lvl_reg        <= top_lvl;
        end
        if (refill_reg)
        begin
            head_hnd_reg[refill_lvl_reg]  <= ent_data_rd_reg[15:0];
            head_blk_reg[refill_lvl_reg]  <= ent_data_rd_reg[16];
            head_next_reg[refill_lvl_reg] <= ent_link_rd_reg;
        end
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (ins_ok)
        begin
            ent_data_mem[alloc_idx] <= {req.data.blocks_others, hnd};
        end
        ent_data_rd_reg <= ent_data_mem[head_next_reg[top_lvl]];
    end

    always_ff @(posedge clk)
    begin
        if (ins_ok && nonempty_reg[ins_lvl] && !one_reg[ins_lvl])
        begin
            ent_link_mem[tail_idx_reg[ins_lvl]] <= alloc_idx;
        end
        ent_link_rd_reg <= ent_link_mem[head_next_reg[top_lvl]];
    end

    // recycled entry fifo, head word kept in rec_rdata_reg
    always_ff @(posedge clk)
    begin
        if (pop_ok)
        begin
            rec_mem[rec_wr_ptr_reg] <= pop_idx;
        end
        if (pop_ok && rec_wr_ptr_reg == rec_rd_ptr_next)
        begin
            rec_rdata_reg <= pop_idx;
        end
        else
        begin
            rec_rdata_reg <= rec_mem[rec_rd_ptr_next];
        end
    end

endmodule

// ----- hdl/spq_checker.sv -----
module spq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input spq_pkg::rsp_item_t rsp_data
);
    import spq_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // every accepted item gives a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no result after accepted item");

    // empty queue and level count agree
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.is_empty == (rsp_data.levels_in_use == 5'd0)))
        else $error("empty flag and level count disagree");

    // only a successful pop hands out a handle or level
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK
        |-> rsp_data.out_handle == 16'd0 && rsp_data.out_level == 4'd0)
        else $error("handle given with error status");

    // a more urgent level implies a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.urgent_present |-> !rsp_data.is_empty)
        else $error("urgent level reported on empty queue");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
